[rtl/core/assert_macros.svh]
// Assertion helpers, included by the light influence counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/plic_pkg.sv]
// ----------------------------------------------------------------------------
// Point light influence counter package
// Widths, register indexes and reset values for the light culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package plic_pkg;

   localparam int CountWidth  = 16;
   localparam int CoordWidth  = 20;
   localparam int CoefWidth   = 24;
   localparam int DistSqWidth = 42;
   localparam int AttWidth    = 32;
   localparam int DistWidth   = 21;
   localparam int AccWidth    = 66;
   localparam int RemWidth    = 24;
   localparam int IndexWidth  = 8;
   localparam int StepWidth   = 5;

   localparam int MulSteps  = CoefWidth;
   localparam int SqrtSteps = DistWidth;

   localparam logic [IndexWidth-1:0] RegCenterX  = IndexWidth'(0);
   localparam logic [IndexWidth-1:0] RegCenterY  = IndexWidth'(1);
   localparam logic [IndexWidth-1:0] RegCenterZ  = IndexWidth'(2);
   localparam logic [IndexWidth-1:0] RegRadiusSq = IndexWidth'(3);
   localparam logic [IndexWidth-1:0] RegAttLimit = IndexWidth'(4);

   localparam logic [AttWidth-1:0]   AttLimitReset = AttWidth'(655360);
   localparam logic [AttWidth-1:0]   AttMax        = {AttWidth{1'b1}};
   localparam logic [CountWidth-1:0] CountMax      = {CountWidth{1'b1}};

endpackage

`default_nettype wire

[rtl/core/point_light_influence_counter.sv]
// ----------------------------------------------------------------------------
// Point light influence counter
// Attenuation test of point lights against one object, with a running count.
// ----------------------------------------------------------------------------
// Usage: one light is offered per request on the req_ channel; tuser marks
// a point light and whether it is switched on, tlast closes the light list.
// Each request yields exactly one response on the rsp_ channel with the pass
// flag, the attenuation and the running count; rsp_tlast repeats req_tlast,
// and the count then holds the list total and clears for the next list. The
// object centre, its squared radius and the attenuation limit are set through
// the csr_ write channel; the user must write only while idle (not enforced).
// A light that is not an enabled point light goes from idle straight to the
// finish state, which registers the response. Other lights run through a
// one bit per cycle shift-and-add multiplier (three squares, each after an
// operand load, then one quadratic product), then a two bit per cycle square
// root and a linear product; the first stage may already settle the result,
// and then the square root and the linear product are skipped. One light is
// in work at a time, so the next request is taken only after the response
// has been accepted and the block is back in idle.
// Reset clears the count and the registers (the limit becomes 10.0). While
// the receiver stalls, the response holds and no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module point_light_influence_counter (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x[19:0], pos_y[39:20], pos_z[59:40], att_const[83:60],
   // att_lin[107:84], att_quad[131:108], zero padding above
   input  wire logic [135:0] req_tdata,
   // is_point[0], enabled[1]
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // counted[0], attenuation[32:1], light_count[48:33], zero padding above
   output logic [55:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [plic_pkg::IndexWidth-1:0]  csr_index,
   input  wire logic [plic_pkg::DistSqWidth-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SQ, ST_RAD, ST_QM, ST_STG1, ST_SQRT, ST_LM,
      ST_LADD, ST_FIN, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [1:0] axis_ff, axis_in;
   logic [plic_pkg::StepWidth-1:0] step_ff, step_in;
   logic [plic_pkg::AccWidth-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [plic_pkg::CoefWidth-1:0] mplier_ff, mplier_in;
   logic [plic_pkg::DistSqWidth-1:0] d2_ff, d2_in, rad_ff, rad_in;
   logic [plic_pkg::RemWidth-1:0] rem_ff, rem_in;
   logic [plic_pkg::DistWidth-1:0] root_ff, root_in;
   logic [plic_pkg::AttWidth-1:0] att_ff, att_in;
   logic pass_ff, pass_in;

   logic [plic_pkg::CoordWidth-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [plic_pkg::DistSqWidth-1:0] rsq_ff, rsq_in;
   logic [plic_pkg::AttWidth-1:0] lim_ff, lim_in;

   logic [plic_pkg::CoordWidth-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [plic_pkg::CoefWidth-1:0] ac_ff, ac_in, al_ff, al_in, aq_ff, aq_in;
   logic last_ff, last_in;

   logic [plic_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   // Datapath helpers
   logic [plic_pkg::CoordWidth-1:0] c_sel, p_sel;
   logic [plic_pkg::DistWidth-1:0]  diff, diff_abs;
   logic [plic_pkg::AccWidth-1:0]   acc_step;
   logic [plic_pkg::DistSqWidth-1:0] d2_clamped;
   logic [plic_pkg::AttWidth-1:0]   qterm, att_stage1, att_final;
   logic [plic_pkg::AttWidth:0]     sum1;
   logic [plic_pkg::DistSqWidth-1:0] sum2;
   logic [plic_pkg::RemWidth-1:0]   rem_sh, trial;
   logic [plic_pkg::DistWidth-1:0]  root_next;
   logic [plic_pkg::CountWidth-1:0] cnt_next;
   logic req_fire, mul_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign mul_done   = (step_ff == plic_pkg::StepWidth'(plic_pkg::MulSteps - 1));

   always_comb begin
      case (axis_ff)
         2'd0: begin
            c_sel = cx_ff;
            p_sel = px_ff;
         end
         2'd1: begin
            c_sel = cy_ff;
            p_sel = py_ff;
         end
         default: begin
            c_sel = cz_ff;
            p_sel = pz_ff;
         end
      endcase
   end

   // Coordinate difference is one bit wider so it never wraps.
   assign diff     = {c_sel[plic_pkg::CoordWidth-1], c_sel}
                   - {p_sel[plic_pkg::CoordWidth-1], p_sel};
   assign diff_abs = diff[plic_pkg::DistWidth-1] ? (~diff + 1'b1) : diff;

   // Shift-and-add: the multiplier drops one bit per cycle.
   assign acc_step = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;

   assign d2_clamped = (acc_ff[plic_pkg::DistSqWidth-1:0] > rsq_ff)
                     ? (acc_ff[plic_pkg::DistSqWidth-1:0] - rsq_ff)
                     : '0;

   // The quadratic product saturates once it reaches 2^40.
   assign qterm = (acc_ff[plic_pkg::AccWidth-1:40] != '0) ? plic_pkg::AttMax
                                                          : acc_ff[39:8];
   assign sum1       = {1'b0, 8'd0, ac_ff} + {1'b0, qterm};
   assign att_stage1 = sum1[plic_pkg::AttWidth] ? plic_pkg::AttMax
                                                : sum1[plic_pkg::AttWidth-1:0];

   assign sum2      = {10'd0, att_ff} + {1'b0, acc_ff[44:4]};
   assign att_final = (sum2[plic_pkg::DistSqWidth-1:plic_pkg::AttWidth] != '0)
                    ? plic_pkg::AttMax : sum2[plic_pkg::AttWidth-1:0];

   // Square root digit: bring down the next two radicand bits and try.
   assign rem_sh    = {rem_ff[plic_pkg::RemWidth-3:0],
                       rad_ff[plic_pkg::DistSqWidth-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign root_next = {root_ff[plic_pkg::DistWidth-2:0], (rem_sh >= trial)};

   assign cnt_next = (pass_ff && (cnt_ff != plic_pkg::CountMax)) ? (cnt_ff + 1'b1)
                                                                 : cnt_ff;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      d2_in        = d2_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      att_in       = att_ff;
      pass_in      = pass_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rsq_in       = rsq_ff;
      lim_in       = lim_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      ac_in        = ac_ff;
      al_in        = al_ff;
      aq_in        = aq_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            plic_pkg::RegCenterX:  cx_in  = csr_data[plic_pkg::CoordWidth-1:0];
            plic_pkg::RegCenterY:  cy_in  = csr_data[plic_pkg::CoordWidth-1:0];
            plic_pkg::RegCenterZ:  cz_in  = csr_data[plic_pkg::CoordWidth-1:0];
            plic_pkg::RegRadiusSq: rsq_in = csr_data;
            plic_pkg::RegAttLimit: lim_in = csr_data[plic_pkg::AttWidth-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               px_in   = req_tdata[19:0];
               py_in   = req_tdata[39:20];
               pz_in   = req_tdata[59:40];
               ac_in   = req_tdata[83:60];
               al_in   = req_tdata[107:84];
               aq_in   = req_tdata[131:108];
               last_in = req_tlast;
               acc_in  = '0;
               axis_in = 2'd0;
               att_in  = '0;
               pass_in = 1'b0;
               state_in = (req_tuser[0] && req_tuser[1]) ? ST_LOAD : ST_FIN;
            end
         end
         ST_LOAD: begin
            mcand_in  = plic_pkg::AccWidth'(diff_abs);
            mplier_in = plic_pkg::CoefWidth'(diff_abs);
            step_in   = '0;
            state_in  = ST_SQ;
         end
         ST_SQ, ST_QM, ST_LM: begin
            acc_in    = acc_step;
            mcand_in  = {mcand_ff[plic_pkg::AccWidth-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[plic_pkg::CoefWidth-1:1]};
            step_in   = step_ff + 1'b1;
            if (mul_done) begin
               case (state_ff)
                  ST_SQ: begin
                     if (axis_ff == 2'd2) begin
                        state_in = ST_RAD;
                     end else begin
                        axis_in  = axis_ff + 1'b1;
                        state_in = ST_LOAD;
                     end
                  end
                  ST_QM:   state_in = ST_STG1;
                  default: state_in = ST_LADD;
               endcase
            end
         end
         ST_RAD: begin
            d2_in     = d2_clamped;
            mcand_in  = plic_pkg::AccWidth'(d2_clamped);
            mplier_in = aq_ff;
            acc_in    = '0;
            step_in   = '0;
            state_in  = ST_QM;
         end
         ST_STG1: begin
            att_in = att_stage1;
            if (att_stage1 > lim_ff) begin
               pass_in  = 1'b0;
               state_in = ST_FIN;
            end else if (al_ff == '0) begin
               pass_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               rad_in   = d2_ff;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
            root_in = root_next;
            rad_in  = {rad_ff[plic_pkg::DistSqWidth-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == plic_pkg::StepWidth'(plic_pkg::SqrtSteps - 1)) begin
               mcand_in  = plic_pkg::AccWidth'(root_next);
               mplier_in = al_ff;
               acc_in    = '0;
               step_in   = '0;
               state_in  = ST_LM;
            end
         end
         ST_LADD: begin
            att_in   = att_final;
            pass_in  = (att_final <= lim_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_data_in  = {7'd0, 16'(cnt_next), att_ff, pass_ff};
            rsp_last_in  = last_ff;
            rsp_valid_in = 1'b1;
            cnt_in       = last_ff ? '0 : cnt_next;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         rsq_ff       <= '0;
         lim_ff       <= plic_pkg::AttLimitReset;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         rsq_ff       <= rsq_in;
         lim_ff       <= lim_in;
      end
      axis_ff     <= axis_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      d2_ff       <= d2_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      att_ff      <= att_in;
      pass_ff     <= pass_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      ac_ff       <= ac_in;
      al_ff       <= al_in;
      aq_ff       <= aq_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // A new request is never taken while a response is still pending.
   `ASSERT_CLK(a_no_overlap, clock, reset, req_tready |-> !rsp_tvalid, "request taken while response pending")

   // A counted light never reports an attenuation above the limit.
   `ASSERT_CLK(a_pass_limit, clock, reset, (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[32:1] <= lim_ff), "counted light above limit")

   // A counted light always leaves a nonzero count behind it.
   `ASSERT_CLK(a_pass_count, clock, reset, (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[48:33] != 16'd0), "counted light with zero count")

endmodule

`default_nettype wire
